>>> sv/xmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmb_pkg
// Shared constants and the result item type of the XMODEM block receiver.
// ----------------------------------------------------------------------------
package xmb_pkg;

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH  = 8'h01;
  localparam logic [7:0] BYTE_EOT  = 8'h04;
  localparam logic [7:0] BYTE_ACK  = 8'h06;
  localparam logic [7:0] BYTE_ETB  = 8'h17;
  localparam logic [7:0] BYTE_RDY  = 8'h43;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_NONE = 8'h00;

  // Input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Packet layout
  localparam int PACKET_BYTES    = 133;
  localparam int WORDS_PER_BLOCK = 64;
  localparam int DATA_START      = 3;
  localparam int ADDR_W          = $clog2(PACKET_BYTES);
  localparam int WORD_IDX_W      = $clog2(WORDS_PER_BLOCK);

  // Field widths
  localparam int OFFSET_W = 18;
  localparam int DATA_W   = 16;
  localparam int MS_W     = 16;

  localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd3000;

  // One result item
  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                write_valid;
    logic [OFFSET_W-1:0] write_offset;
    logic [DATA_W-1:0]   write_data;
    logic                overflow;
    logic                finished;
    logic                last;
  } item_t;

endpackage
`default_nettype wire

>>> sv/xmb_packet_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmb_packet_ram
// Packet byte store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module xmb_packet_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic                      re_i,
  input  wire logic [xmb_pkg::ADDR_W-1:0] addr_i,
  input  wire logic [7:0]                wdata_i,
  output logic      [7:0]                rdata_o
);

  logic [7:0] mem_q [xmb_pkg::PACKET_BYTES];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/xmb_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmb_out_reg
// Single-entry output register for result items with valid/stall handshake.
// ----------------------------------------------------------------------------
module xmb_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire xmb_pkg::item_t item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output xmb_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  xmb_pkg::item_t item_q;

  // Slot is free when empty or being taken this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;

endmodule
`default_nettype wire

>>> sv/xmodem_block_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM receiver for 128-byte blocks, sequenced over a single-port packet
// store.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one received byte or one
// millisecond tick per item. Output channel (out_valid_o / out_stall_i)
// carries result items: bytes to send back ('C', ACK), data words to write
// at image word offsets, overflow and finished flags; last_o marks the final
// result of an input item. cfg_we_i / cfg_wdata_i load timeout_ms; the user
// must write it only while idle, which the block itself does not enforce.
// An item may yield no reply, one or two; no input item is taken until the
// sequencer is done with the last one and idle again. The item that completes
// a block emits 64 words, each by two byte reads from the packet store's one
// port, then the push, or one overflow-flagged ACK if the image has no room.
// Results go through a one-item output register, so a stalled receiver just
// holds the sequencer at its push until the slot frees up.
// Reset: timeout_ms = 3000, transfer restarts with a 'C' on the first input
// item; the packet store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module xmodem_block_receiver #(
  parameter int IMAGE_WORDS = 262144
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rx_byte_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             tx_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             write_valid_o,
  output logic [17:0]      write_offset_o,
  output logic [15:0]      write_data_o,
  output logic             overflow_o,
  output logic             finished_o,
  output logic             last_o
);

  localparam int NXT_W = $clog2(IMAGE_WORDS + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECIDE  = 7'b0000010,
    S_EMIT    = 7'b0000100,
    S_COLLECT = 7'b0001000,
    S_RD_LO   = 7'b0010000,
    S_RD_HI   = 7'b0100000,
    S_WORD    = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_CLOSING = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  state_e state_q, state_d, after_q, after_d;
  phase_e phase_q, phase_d;

  logic [xmb_pkg::ADDR_W-1:0]     count_q, count_d;
  logic [7:0]                     first_q, first_d;
  logic [xmb_pkg::MS_W-1:0]       elapsed_q, elapsed_d;
  logic [xmb_pkg::MS_W-1:0]       timeout_q;
  logic [NXT_W-1:0]               next_q, next_d;
  logic [NXT_W-1:0]               wofs_q, wofs_d;
  logic [xmb_pkg::WORD_IDX_W-1:0] k_q, k_d;
  logic [7:0]                     lo_q, lo_d;
  logic                           mode_q;
  logic [7:0]                     byte_q;
  xmb_pkg::item_t                 pend_q, pend_d;

  logic                       push;
  xmb_pkg::item_t             push_item;
  logic                       out_ready;
  xmb_pkg::item_t             out_item;
  logic                       ram_we, ram_re;
  logic [xmb_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                 ram_rdata;

  logic [xmb_pkg::MS_W-1:0]   el_inc;
  logic [NXT_W:0]             nxt_sum;
  logic                       blk_ovf;
  logic [7:0]                 first_byte;
  logic                       last_word;
  logic [xmb_pkg::ADDR_W-1:0] lo_addr;

  function automatic logic [xmb_pkg::OFFSET_W-1:0] to_off(input logic [NXT_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[xmb_pkg::OFFSET_W-1:0];
  endfunction

  function automatic xmb_pkg::item_t make_item(
    input logic [7:0]                    tx,
    input logic                          wv,
    input logic [xmb_pkg::OFFSET_W-1:0]  wo,
    input logic [xmb_pkg::DATA_W-1:0]    wd,
    input logic                          ov,
    input logic                          fin,
    input logic                          lst
  );
    xmb_pkg::item_t it;
    it.tx_valid     = (tx != xmb_pkg::BYTE_NONE);
    it.tx_byte      = tx;
    it.write_valid  = wv;
    it.write_offset = wo;
    it.write_data   = wd;
    it.overflow     = ov;
    it.finished     = fin;
    it.last         = lst;
    return it;
  endfunction

  // Shared helpers: saturating tick count, capacity check, first byte, last word, word address
  assign el_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign nxt_sum    = {1'b0, next_q} + (NXT_W + 1)'(xmb_pkg::WORDS_PER_BLOCK);
  assign blk_ovf    = nxt_sum > (NXT_W + 1)'(IMAGE_WORDS);
  assign first_byte = (count_q == '0) ? byte_q : first_q;
  assign last_word  = (k_q == xmb_pkg::WORD_IDX_W'(xmb_pkg::WORDS_PER_BLOCK - 1));
  assign lo_addr    = xmb_pkg::ADDR_W'(xmb_pkg::DATA_START)
                    + xmb_pkg::ADDR_W'({k_q, 1'b0});

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    after_d   = after_q;
    phase_d   = phase_q;
    count_d   = count_q;
    first_d   = first_q;
    elapsed_d = elapsed_q;
    next_d    = next_q;
    wofs_d    = wofs_q;
    k_d       = k_q;
    lo_d      = lo_q;
    pend_d    = pend_q;
    push      = 1'b0;
    push_item = pend_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        unique case (phase_q)
          PH_START: begin
            phase_d   = PH_COLLECT;
            count_d   = '0;
            elapsed_d = '0;
            pend_d    = make_item(xmb_pkg::BYTE_RDY, 1'b0, '0, '0, 1'b0, 1'b0,
                                  !(mode_q == xmb_pkg::MODE_BYTE &&
                                    (byte_q == xmb_pkg::BYTE_EOT ||
                                     byte_q == xmb_pkg::BYTE_ETB)));
            after_d   = (mode_q == xmb_pkg::MODE_BYTE) ? S_COLLECT : S_IDLE;
            state_d   = S_EMIT;
          end
          PH_COLLECT: begin
            if (mode_q == xmb_pkg::MODE_TICK) begin
              if (el_inc >= timeout_q) begin
                count_d   = '0;
                elapsed_d = '0;
                pend_d    = make_item(xmb_pkg::BYTE_RDY, 1'b0, '0, '0, 1'b0, 1'b0,
                                      1'b1);
                after_d   = S_IDLE;
                state_d   = S_EMIT;
              end else begin
                elapsed_d = el_inc;
                state_d   = S_IDLE;
              end
            end else begin
              state_d = S_COLLECT;
            end
          end
          PH_CLOSING: begin
            state_d = S_IDLE;
            if (mode_q == xmb_pkg::MODE_BYTE) begin
              if (byte_q == xmb_pkg::BYTE_EOT || byte_q == xmb_pkg::BYTE_ETB) begin
                pend_d  = make_item(xmb_pkg::BYTE_ACK, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
                after_d = S_IDLE;
                state_d = S_EMIT;
              end else if (byte_q == xmb_pkg::BYTE_CR) begin
                phase_d = PH_DONE;
                pend_d  = make_item(xmb_pkg::BYTE_NONE, 1'b0, '0, '0, 1'b0, 1'b1,
                                    1'b1);
                after_d = S_IDLE;
                state_d = S_EMIT;
              end
            end
          end
          PH_DONE: begin
            state_d = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // Hand one prepared item to the output register
      S_EMIT: begin
        if (out_ready) begin
          push    = 1'b1;
          state_d = after_q;
        end
      end

      // Store a byte and look at the packet's first byte
      S_COLLECT: begin
        elapsed_d = '0;
        if (count_q == '0) begin
          first_d = byte_q;
        end
        if (count_q < xmb_pkg::ADDR_W'(xmb_pkg::PACKET_BYTES)) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
        state_d = S_IDLE;
        if (first_byte == xmb_pkg::BYTE_SOH) begin
          if (count_q == xmb_pkg::ADDR_W'(xmb_pkg::PACKET_BYTES - 1)) begin
            count_d = '0;
            if (blk_ovf) begin
              pend_d  = make_item(xmb_pkg::BYTE_ACK, 1'b0, to_off(next_q), '0, 1'b1,
                                  1'b0, 1'b1);
              after_d = S_IDLE;
              state_d = S_EMIT;
            end else begin
              k_d     = '0;
              wofs_d  = next_q;
              state_d = S_RD_LO;
            end
          end
        end else if (first_byte == xmb_pkg::BYTE_EOT ||
                     first_byte == xmb_pkg::BYTE_ETB) begin
          phase_d = PH_CLOSING;
          pend_d  = make_item(xmb_pkg::BYTE_ACK, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
          after_d = S_IDLE;
          state_d = S_EMIT;
        end else begin
          count_d = '0;
        end
      end

      // Word loop: read low byte, read high byte, push the word
      S_RD_LO: begin
        ram_re   = 1'b1;
        ram_addr = lo_addr;
        state_d  = S_RD_HI;
      end

      S_RD_HI: begin
        ram_re   = 1'b1;
        ram_addr = lo_addr + 1'b1;
        lo_d     = ram_rdata;
        state_d  = S_WORD;
      end

      S_WORD: begin
        push_item = make_item(last_word ? xmb_pkg::BYTE_ACK : xmb_pkg::BYTE_NONE,
                              1'b1, to_off(wofs_q), {ram_rdata, lo_q}, 1'b0, 1'b0,
                              last_word);
        if (out_ready) begin
          push   = 1'b1;
          wofs_d = wofs_q + 1'b1;
          if (last_word) begin
            next_d  = wofs_q + 1'b1;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_RD_LO;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      after_q   <= S_IDLE;
      phase_q   <= PH_START;
      count_q   <= '0;
      elapsed_q <= '0;
      next_q    <= '0;
      timeout_q <= xmb_pkg::TIMEOUT_RESET;
      k_q       <= '0;
      wofs_q    <= '0;
    end else begin
      state_q   <= state_d;
      after_q   <= after_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
      next_q    <= next_d;
      k_q       <= k_d;
      wofs_q    <= wofs_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    lo_q    <= lo_d;
    pend_q  <= pend_d;
    if (state_q == S_IDLE && in_valid_i) begin
      mode_q <= mode_i;
      byte_q <= rx_byte_i;
    end
  end

  xmb_packet_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (byte_q),
    .rdata_o (ram_rdata)
  );

  xmb_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (out_item)
  );

  assign tx_valid_o     = out_item.tx_valid;
  assign tx_byte_o      = out_item.tx_byte;
  assign write_valid_o  = out_item.write_valid;
  assign write_offset_o = out_item.write_offset;
  assign write_data_o   = out_item.write_data;
  assign overflow_o     = out_item.overflow;
  assign finished_o     = out_item.finished;
  assign last_o         = out_item.last;

endmodule
`default_nettype wire

>>> bench/xmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmb_checker
// Watches both channels of the XMODEM block receiver, predicts every result
// item from the accepted input items and the timeout setting, and compares
// the results field by field in order. Hands its mismatch count and the
// number of outstanding expected items to the bench top.
// ----------------------------------------------------------------------------
module xmb_checker #(
  parameter int IMAGE_WORDS = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        tx_valid_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        write_valid_i,
  input  logic [17:0] write_offset_i,
  input  logic [15:0] write_data_i,
  input  logic        overflow_i,
  input  logic        finished_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [1:0] {
    ST_SEND_C,
    ST_COLLECT,
    ST_CLOSING,
    ST_DONE
  } xfer_state_e;

  // Transfer state as the receiver should hold it
  xfer_state_e              xfer_state = ST_SEND_C;
  logic [7:0]               pkt_buf [xmb_pkg::PACKET_BYTES];
  int                       rx_count   = 0;
  logic [xmb_pkg::MS_W-1:0] idle_ms    = '0;
  logic [xmb_pkg::MS_W-1:0] timeout_ms = xmb_pkg::TIMEOUT_RESET;
  int                       image_ptr  = 0;   // not truncated, may reach IMAGE_WORDS
  int                       mismatches = 0;

  xmb_pkg::item_t write_q[$];   // result items still owed by the receiver, oldest first
  xmb_pkg::item_t reply_q[$];   // result items of the input item being predicted

  function automatic xmb_pkg::item_t make_item(input logic [7:0] tx, input logic wv,
                                               input logic [xmb_pkg::OFFSET_W-1:0] wo,
                                               input logic [xmb_pkg::DATA_W-1:0] wd,
                                               input logic ov);
    xmb_pkg::item_t it;
    it.tx_valid     = (tx != xmb_pkg::BYTE_NONE);
    it.tx_byte      = tx;
    it.write_valid  = wv;
    it.write_offset = wo;
    it.write_data   = wd;
    it.overflow     = ov;
    it.finished     = (xfer_state == ST_DONE);
    it.last         = 1'b0;
    return it;
  endfunction

  // One byte while collecting: store it and act on the packet's first byte
  task automatic take_byte(input logic [7:0] b);
    logic [xmb_pkg::DATA_W-1:0] word;
    idle_ms = '0;
    if (rx_count < xmb_pkg::PACKET_BYTES) begin
      pkt_buf[rx_count] = b;
      rx_count++;
    end
    case (pkt_buf[0])
      xmb_pkg::BYTE_SOH: begin
        if (rx_count >= xmb_pkg::PACKET_BYTES) begin
          if (image_ptr + xmb_pkg::WORDS_PER_BLOCK > IMAGE_WORDS) begin
            // no room left: flag it, ACK anyway, offset stays
            reply_q.push_back(make_item(xmb_pkg::BYTE_ACK, 1'b0,
                                        xmb_pkg::OFFSET_W'(image_ptr), '0, 1'b1));
          end else begin
            for (int k = 0; k < xmb_pkg::WORDS_PER_BLOCK; k++) begin
              word = {pkt_buf[xmb_pkg::DATA_START + 2 * k + 1],
                      pkt_buf[xmb_pkg::DATA_START + 2 * k]};
              reply_q.push_back(make_item((k == xmb_pkg::WORDS_PER_BLOCK - 1) ?
                                          xmb_pkg::BYTE_ACK : xmb_pkg::BYTE_NONE,
                                          1'b1, xmb_pkg::OFFSET_W'(image_ptr + k),
                                          word, 1'b0));
            end
            image_ptr = image_ptr + xmb_pkg::WORDS_PER_BLOCK;
          end
          rx_count = 0;
        end
      end
      xmb_pkg::BYTE_EOT, xmb_pkg::BYTE_ETB: begin
        reply_q.push_back(make_item(xmb_pkg::BYTE_ACK, 1'b0, '0, '0, 1'b0));
        xfer_state = ST_CLOSING;
      end
      default: rx_count = 0;
    endcase
  endtask

  // Work out the result items of one accepted input item
  task automatic predict_results(input logic m, input logic [7:0] b);
    xmb_pkg::item_t tail;
    reply_q.delete();
    case (xfer_state)
      ST_SEND_C: begin
        rx_count   = 0;
        idle_ms    = '0;
        xfer_state = ST_COLLECT;
        reply_q.push_back(make_item(xmb_pkg::BYTE_RDY, 1'b0, '0, '0, 1'b0));
        if (m == xmb_pkg::MODE_BYTE) take_byte(b);
      end
      ST_COLLECT: begin
        if (m == xmb_pkg::MODE_TICK) begin
          if (idle_ms != '1) idle_ms++;
          if (idle_ms >= timeout_ms) begin
            rx_count = 0;
            idle_ms  = '0;
            reply_q.push_back(make_item(xmb_pkg::BYTE_RDY, 1'b0, '0, '0, 1'b0));
          end
        end else begin
          take_byte(b);
        end
      end
      ST_CLOSING: begin
        // late end markers get ACKed again, CR ends the transfer
        if (m == xmb_pkg::MODE_BYTE) begin
          if (b == xmb_pkg::BYTE_EOT || b == xmb_pkg::BYTE_ETB) begin
            reply_q.push_back(make_item(xmb_pkg::BYTE_ACK, 1'b0, '0, '0, 1'b0));
          end else if (b == xmb_pkg::BYTE_CR) begin
            xfer_state = ST_DONE;
            reply_q.push_back(make_item(xmb_pkg::BYTE_NONE, 1'b0, '0, '0, 1'b0));
          end
        end
      end
      default: ;
    endcase
    if (reply_q.size() > 0) begin
      tail      = reply_q.pop_back();
      tail.last = 1'b1;
      reply_q.push_back(tail);
    end
    foreach (reply_q[i]) write_q.push_back(reply_q[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare accepted results, then track config and accepted input items
  always @(posedge clk_i or negedge rst_ni) begin
    xmb_pkg::item_t want;
    if (!rst_ni) begin
      xfer_state = ST_SEND_C;
      rx_count   = 0;
      idle_ms    = '0;
      timeout_ms = xmb_pkg::TIMEOUT_RESET;
      image_ptr  = 0;
      mismatches = 0;
      write_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (write_q.size() == 0) begin
          $error("result item with nothing expected (tx_byte 0x%0h)", tx_byte_i);
          mismatches++;
        end else begin
          want = write_q.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid_i));
          check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte_i));
          check_field("write_valid", 32'(want.write_valid), 32'(write_valid_i));
          check_field("write_offset", 32'(want.write_offset), 32'(write_offset_i));
          check_field("write_data", 32'(want.write_data), 32'(write_data_i));
          check_field("overflow", 32'(want.overflow), 32'(overflow_i));
          check_field("finished", 32'(want.finished), 32'(finished_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (cfg_we_i) timeout_ms = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_results(mode_i, rx_byte_i);
      fail_count_o <= mismatches;
      pending_o    <= write_q.size();
    end
  end

endmodule

>>> bench/tb_xmodem_block_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xmodem_block_receiver
// Drives the XMODEM block receiver with received bytes and millisecond ticks:
// directed openers, timeouts at small settings including the shortest, one
// well-formed block that fills the image exactly under a long result
// hold-off, and the closing handshake. Both channels idle at random; results
// are predicted and compared by xmb_checker.
// ----------------------------------------------------------------------------
module tb_xmodem_block_receiver;

  localparam int IMG_WORDS     = 64;       // one block fills the image exactly
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 250;      // covers one full block emission
  localparam int CYCLE_LIMIT   = 50000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        mode      = xmb_pkg::MODE_BYTE;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        write_valid;
  logic [17:0] write_offset;
  logic [15:0] write_data;
  logic        overflow;
  logic        finished;
  logic        last;
  int          fail_count;
  int          pending;

  bit calm     = 1'b0;   // no random idling on either side
  bit hold_req = 1'b0;   // ask the result side for one long hold-off
  int tmo      = int'(xmb_pkg::TIMEOUT_RESET);
  int cycles   = 0;

  xmodem_block_receiver #(
    .IMAGE_WORDS(IMG_WORDS)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .tx_valid_o    (tx_valid),
    .tx_byte_o     (tx_byte),
    .write_valid_o (write_valid),
    .write_offset_o(write_offset),
    .write_data_o  (write_data),
    .overflow_o    (overflow),
    .finished_o    (finished),
    .last_o        (last)
  );

  xmb_checker #(
    .IMAGE_WORDS(IMG_WORDS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .mode_i        (mode),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .tx_valid_i    (tx_valid),
    .tx_byte_i     (tx_byte),
    .write_valid_i (write_valid),
    .write_offset_i(write_offset),
    .write_data_i  (write_data),
    .overflow_i    (overflow),
    .finished_i    (finished),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 30);
    end
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input logic m, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(xmb_pkg::MODE_TICK, 8'($urandom_range(255)));
  endtask

  // First byte that is neither SOH nor an end marker
  task automatic send_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == xmb_pkg::BYTE_SOH || b == xmb_pkg::BYTE_EOT || b == xmb_pkg::BYTE_ETB);
    send_item(xmb_pkg::MODE_BYTE, b);
  endtask

  // SOH, block number, its complement, then payload; short of the timeout
  // a few ticks may fall between bytes
  task automatic send_frame(input int n_bytes, input bit hold);
    logic [7:0] blk;
    int         span;
    blk  = 8'($urandom_range(255));
    span = (tmo > 8) ? 8 : tmo;
    for (int i = 0; i < n_bytes; i++) begin
      if (i > 0 && span > 1 && $urandom_range(63) == 0) begin
        send_ticks(int'($urandom_range(1, span - 1)));
      end
      if (hold && i == n_bytes - 1) hold_req = 1'b1;
      case (i)
        0:       send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_SOH);
        1:       send_item(xmb_pkg::MODE_BYTE, blk);
        2:       send_item(xmb_pkg::MODE_BYTE, ~blk);
        default: send_item(xmb_pkg::MODE_BYTE, pick_byte());
      endcase
    end
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic retune(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tmo = int'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    int         r;
    logic [7:0] b;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First item after reset is a tick or a noise byte, 'C' either way
    if ($urandom_range(1) != 0) send_ticks(1);
    else send_noise();
    send_item(xmb_pkg::MODE_BYTE, 8'h00);
    send_item(xmb_pkg::MODE_BYTE, 8'hFF);
    send_ticks(3);

    // Shortest timeout: every tick restarts, also mid-packet
    retune(16'd1);
    send_ticks(2);
    send_frame(int'($urandom_range(2, 8)), 1'b0);
    send_ticks(1);

    // Small timeout counted out to the restart
    retune(16'($urandom_range(2, 6)));
    send_noise();
    send_ticks(tmo);

    // One full block without idling, long hold-off while bytes keep coming
    retune(16'd40);
    calm = 1'b1;
    send_frame(xmb_pkg::PACKET_BYTES, 1'b1);
    calm = 1'b0;

    // Closing: end marker, late markers, noise and ticks, then CR
    send_item(xmb_pkg::MODE_BYTE,
              ($urandom_range(1) != 0) ? xmb_pkg::BYTE_EOT : xmb_pkg::BYTE_ETB);
    send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_EOT);
    send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_ETB);
    repeat (6) begin
      r = $urandom_range(3);
      case (r)
        0: send_item(xmb_pkg::MODE_BYTE,
                     ($urandom_range(1) != 0) ? xmb_pkg::BYTE_EOT : xmb_pkg::BYTE_ETB);
        1: send_ticks(1);
        default: begin
          do b = 8'($urandom_range(255));
          while (b == xmb_pkg::BYTE_EOT || b == xmb_pkg::BYTE_ETB || b == xmb_pkg::BYTE_CR);
          send_item(xmb_pkg::MODE_BYTE, b);
        end
      endcase
    end
    send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_CR);

    // Transfer over: everything is ignored
    repeat (3) begin
      r = $urandom_range(3);
      case (r)
        0:       send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_EOT);
        1:       send_item(xmb_pkg::MODE_BYTE, xmb_pkg::BYTE_CR);
        2:       send_ticks(1);
        default: send_item(xmb_pkg::MODE_BYTE, 8'($urandom_range(255)));
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
